// ===== hdl/arbb_pkg.sv =====
package arbb_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Saturation bounds of the 32-bit signed result range.
  localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

  // Width of the exact mapped coordinates: four 64-bit products, one offset.
  localparam int SUM_W = 67;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_XY  = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_COEF_YX  = 3'd3,
    REG_COEF_YY  = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_reg_t;

  // One input item: the source rectangle.
  typedef struct packed {
    logic signed [31:0] rect_left;
    logic signed [31:0] rect_top;
    logic signed [31:0] rect_width;
    logic signed [31:0] rect_height;
  } rect_t;

  // One result item: the bounding box of the mapped corners.
  typedef struct packed {
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic        [30:0] box_width;
    logic        [30:0] box_height;
    logic               range_overflow;
  } box_t;

  // Transform coefficients as held by the register file.
  typedef struct packed {
    logic signed [31:0] coef_xx;
    logic signed [31:0] coef_xy;
    logic signed [31:0] offset_x;
    logic signed [31:0] coef_yx;
    logic signed [31:0] coef_yy;
    logic signed [31:0] offset_y;
  } coef_t;

endpackage

// ===== hdl/arbb_cfg_regs.sv =====
module arbb_cfg_regs #(
  parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [arbb_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]                    wr_data,
  output arbb_pkg::coef_t                coef
);

  // The identity weight is 1.0 in the chosen fixed-point format.
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  // Register file; writes to unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.coef_xx  <= ONE;
      coef.coef_xy  <= '0;
      coef.offset_x <= '0;
      coef.coef_yx  <= '0;
      coef.coef_yy  <= ONE;
      coef.offset_y <= '0;
    end else if (wr_en) begin
      case (arbb_pkg::cfg_reg_t'(wr_index))
        arbb_pkg::REG_COEF_XX:  coef.coef_xx  <= wr_data;
        arbb_pkg::REG_COEF_XY:  coef.coef_xy  <= wr_data;
        arbb_pkg::REG_OFFSET_X: coef.offset_x <= wr_data;
        arbb_pkg::REG_COEF_YX:  coef.coef_yx  <= wr_data;
        arbb_pkg::REG_COEF_YY:  coef.coef_yy  <= wr_data;
        arbb_pkg::REG_OFFSET_Y: coef.offset_y <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/arbb_axis.sv =====
module arbb_axis #(
  parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic signed [31:0]                   wa,
  input  logic signed [31:0]                   wb,
  input  logic signed [31:0]                   off,
  input  logic signed [31:0]                   l,
  input  logic signed [31:0]                   t,
  input  logic signed [31:0]                   w,
  input  logic signed [31:0]                   h,
  output logic signed [arbb_pkg::SUM_W-1:0]    lo,
  output logic signed [arbb_pkg::SUM_W-1:0]    hi
);

  localparam int S0_W = 65;
  localparam int SX_W = 66;

  logic signed [63:0]      p_l, p_t, p_w, p_h;
  logic signed [S0_W-1:0]  s0;
  logic signed [63:0]      h_neg, h_pos, w_neg, w_pos;
  logic signed [SX_W-1:0]  s_min, s_max;

  // Stage one: the four full-width products of this axis.
  always_ff @(posedge clk) begin
    p_l <= wa * l;
    p_t <= wb * t;
    p_w <= wa * w;
    p_h <= wb * h;
  end

  // Stage two: the top-left corner sum, and the edge terms split by sign.
  // A negative edge term lowers the minimum, a positive one raises the maximum.
  always_ff @(posedge clk) begin
    s0    <= S0_W'(p_l) + S0_W'(p_t);
    h_neg <= p_h[63] ? p_h : '0;
    h_pos <= p_h[63] ? '0 : p_h;
    w_neg <= p_w[63] ? p_w : '0;
    w_pos <= p_w[63] ? '0 : p_w;
  end

  // Stage three: exact smallest and largest corner sums.
  always_ff @(posedge clk) begin
    s_min <= SX_W'(s0) + SX_W'(h_neg) + SX_W'(w_neg);
    s_max <= SX_W'(s0) + SX_W'(h_pos) + SX_W'(w_pos);
  end

  // Stage four: round down once and add the offset. Flooring is monotonic,
  // so the extremes of the sums give the extremes of the mapped corners.
  always_ff @(posedge clk) begin
    lo <= arbb_pkg::SUM_W'(s_min >>> FRAC_BITS) + arbb_pkg::SUM_W'(off);
    hi <= arbb_pkg::SUM_W'(s_max >>> FRAC_BITS) + arbb_pkg::SUM_W'(off);
  end

endmodule

// ===== hdl/affine_rect_bounding_box_core.sv =====
// Affine bounding box core. Each item is a rectangle (left, top, width,
// height) in signed fixed point; the block maps its four corners through
// the affine transform held in the six configuration registers and returns
// the axis-aligned box around them, saturated to 32 bits with a flag. A new
// item is taken on every clock cycle, so busy stays low, and its result
// appears on box with done high once it has passed the pipeline stages in
// order: products, corner sums, extremes, rounding with
// offset, then width and saturation. Results cannot be held off, so
// the receiver must take each one in the cycle that done marks it.
// Configuration writes are always ready and should only be made while no
// item is in flight.
module affine_rect_bounding_box_core #(
  parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  arbb_pkg::rect_t                rect,
  output logic                           done,
  output arbb_pkg::box_t                 box,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int AXIS_LAT = 4;
  localparam int SW = arbb_pkg::SUM_W;

  arbb_pkg::coef_t      coef;
  logic [AXIS_LAT-1:0]  vld;
  logic signed [SW-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [SW-1:0] x_span, y_span;
  logic                 x_lo_sat_hi, x_lo_sat_lo, y_lo_sat_hi, y_lo_sat_lo;
  logic                 x_span_sat, y_span_sat;

  // The pipeline never stalls, so items and writes are always taken.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  arbb_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  arbb_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk (clk),
    .wa  (coef.coef_xx),
    .wb  (coef.coef_xy),
    .off (coef.offset_x),
    .l   (rect.rect_left),
    .t   (rect.rect_top),
    .w   (rect.rect_width),
    .h   (rect.rect_height),
    .lo  (x_lo),
    .hi  (x_hi)
  );

  arbb_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk (clk),
    .wa  (coef.coef_yx),
    .wb  (coef.coef_yy),
    .off (coef.offset_y),
    .l   (rect.rect_left),
    .t   (rect.rect_top),
    .w   (rect.rect_width),
    .h   (rect.rect_height),
    .lo  (y_lo),
    .hi  (y_hi)
  );

  // Valid bits follow the items through the axis pipelines.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[AXIS_LAT-2:0], start & ~busy};
      done <= vld[AXIS_LAT-1];
    end
  end

  // Spans come from the exact extremes, before any saturation.
  always_comb begin
    x_span      = x_hi - x_lo;
    y_span      = y_hi - y_lo;
    x_lo_sat_hi = x_lo > arbb_pkg::S32_MAX;
    x_lo_sat_lo = x_lo < arbb_pkg::S32_MIN;
    y_lo_sat_hi = y_lo > arbb_pkg::S32_MAX;
    y_lo_sat_lo = y_lo < arbb_pkg::S32_MIN;
    x_span_sat  = x_span > arbb_pkg::S32_MAX;
    y_span_sat  = y_span > arbb_pkg::S32_MAX;
  end

  // Output stage: saturate each value and gather the overflow flag.
  always_ff @(posedge clk) begin
    box.box_left <= x_lo_sat_hi ? 32'sh7FFF_FFFF :
                    x_lo_sat_lo ? 32'sh8000_0000 : x_lo[31:0];
    box.box_top  <= y_lo_sat_hi ? 32'sh7FFF_FFFF :
                    y_lo_sat_lo ? 32'sh8000_0000 : y_lo[31:0];
    box.box_width  <= x_span_sat ? '1 : x_span[30:0];
    box.box_height <= y_span_sat ? '1 : y_span[30:0];
    box.range_overflow <= x_lo_sat_hi | x_lo_sat_lo | y_lo_sat_hi | y_lo_sat_lo |
                          x_span_sat | y_span_sat;
  end

endmodule

// ===== tb/tb_affine_rect_bounding_box_core.sv =====
module tb_affine_rect_bounding_box_core;
  import arbb_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int LATENCY   = 5;
  localparam int IDLE_MAX  = 500;
  localparam int RAND_SETS = 17;
  localparam int SET_ITEMS = 100;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN   = 32'h8000_0000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  rect_t                rect = '0;
  logic                 done;
  box_t                 box;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Shadow copy of the transform registers and the boxes still owed.
  coef_t coef_model;
  box_t  pending_boxes[$];
  int    gap_max = 6;
  int    err_count = 0;
  int    rects_sent = 0;
  int    boxes_checked = 0;
  int    boxes_saturated = 0;
  int    reg_writes = 0;
  int    transforms_used = 0;
  int    idle_cycles = 0;

  affine_rect_bounding_box_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .rect      (rect),
    .done      (done),
    .box       (box),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Smallest and largest mapped coordinate of one output axis, kept exact.
  function automatic void axis_extent(input logic signed [31:0] wa,
                                      input logic signed [31:0] wb,
                                      input logic signed [31:0] off,
                                      input rect_t r,
                                      output logic signed [71:0] lo,
                                      output logic signed [71:0] hi);
    logic signed [71:0] a, b, o, l, t, w, h, v;
    a = wa;
    b = wb;
    o = off;
    l = $signed(r.rect_left);
    t = $signed(r.rect_top);
    w = $signed(r.rect_width);
    h = $signed(r.rect_height);
    lo = '0;
    hi = '0;
    for (int c = 0; c < 4; c++) begin
      v = a * l + b * t;
      if ((c & 1) != 0) v = v + b * h;
      if ((c & 2) != 0) v = v + a * w;
      v = (v >>> FRAC) + o;
      if (c == 0 || v < lo) lo = v;
      if (c == 0 || v > hi) hi = v;
    end
  endfunction

  function automatic logic [31:0] clamp_s32(input logic signed [71:0] v, inout bit ovf);
    if (v > S32_MAX) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (v < S32_MIN) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [30:0] clamp_u31(input logic signed [71:0] v, inout bit ovf);
    if (v > S32_MAX) begin
      ovf = 1'b1;
      return '1;
    end
    return v[30:0];
  endfunction

  // Bounding box of the rectangle under the current transform.
  function automatic box_t predict_box(input rect_t r, input coef_t c);
    box_t               b;
    logic signed [71:0] xl, xh, yl, yh;
    bit                 ovf;
    ovf = 1'b0;
    axis_extent(c.coef_xx, c.coef_xy, c.offset_x, r, xl, xh);
    axis_extent(c.coef_yx, c.coef_yy, c.offset_y, r, yl, yh);
    b.box_left       = clamp_s32(xl, ovf);
    b.box_top        = clamp_s32(yl, ovf);
    b.box_width      = clamp_u31(xh - xl, ovf);
    b.box_height     = clamp_u31(yh - yl, ovf);
    b.range_overflow = ovf;
    return b;
  endfunction

  // Sends one rectangle after a random pause and records the box it owes.
  task automatic send_rect(input rect_t r);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    rect  <= r;
    do @(posedge clk); while (busy);
    pending_boxes.push_back(predict_box(r, coef_model));
    rects_sent++;
  endtask

  task automatic send_rect4(input logic [31:0] l, input logic [31:0] t,
                            input logic [31:0] w, input logic [31:0] h);
    rect_t r;
    r.rect_left   = l;
    r.rect_top    = t;
    r.rect_width  = w;
    r.rect_height = h;
    send_rect(r);
  endtask

  // One register write; the shadow copy follows only decoded indexes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (cfg_reg_t'(idx))
      REG_COEF_XX:  coef_model.coef_xx  = val;
      REG_COEF_XY:  coef_model.coef_xy  = val;
      REG_OFFSET_X: coef_model.offset_x = val;
      REG_COEF_YX:  coef_model.coef_yx  = val;
      REG_COEF_YY:  coef_model.coef_yy  = val;
      REG_OFFSET_Y: coef_model.offset_y = val;
      default: ;
    endcase
  endtask

  // Loads a whole transform, optionally mixed with writes to unused indexes.
  task automatic load_transform(input coef_t c, input bit with_unused);
    if (with_unused) write_reg(REG_UNUSED_LO, $urandom);
    write_reg(REG_COEF_XX, c.coef_xx);
    write_reg(REG_COEF_XY, c.coef_xy);
    write_reg(REG_OFFSET_X, c.offset_x);
    if (with_unused) write_reg(REG_UNUSED_HI, $urandom);
    write_reg(REG_COEF_YX, c.coef_yx);
    write_reg(REG_COEF_YY, c.coef_yy);
    write_reg(REG_OFFSET_Y, c.offset_y);
    cfg_valid <= 1'b0;
    @(posedge clk);
    transforms_used++;
  endtask

  // Lets every owed box come back before the registers are touched.
  task automatic drain;
    start <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      7:          return Q_MAX;
      8:          return Q_MIN;
      default:    return int'($urandom_range(0, 2)) - 1;
    endcase
  endfunction

  function automatic logic [31:0] rand_weight;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      6:       return Q_ONE;
      7:       return -Q_ONE;
      8:       return '0;
      default: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    endcase
  endfunction

  // Identity transform: extremes of every field, negative sizes, zero.
  task automatic test_identity_extremes;
    send_rect4('0, '0, '0, '0);
    send_rect4(32'h0001_0000, 32'h0002_0000, 32'h0003_8000, 32'h0004_4000);
    send_rect4(32'h0005_0000, -32'sh0002_0000, -32'sh0007_0000, -32'sh0001_8000);
    send_rect4(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_rect4(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_rect4(Q_MAX, Q_MIN, Q_MIN, Q_MAX);
    send_rect4(Q_MIN, Q_MAX, Q_MAX, Q_MIN);
    drain();
  endtask

  // Every register, unused indexes and rounding down of negative odd products.
  task automatic test_register_set;
    coef_t c;
    c.coef_xx  = 32'h0000_8000;
    c.coef_xy  = -32'sh0000_C000;
    c.offset_x = Q_MIN;
    c.coef_yx  = Q_MAX;
    c.coef_yy  = Q_MIN;
    c.offset_y = Q_MAX;
    load_transform(c, 1'b1);
    send_rect4(-32'sh0000_0001, 32'h0000_0003, 32'h0000_0001, -32'sh0000_0005);
    send_rect4(32'h0001_0000, -32'sh0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_rect4(-32'sh0000_0007, -32'sh0000_0003, '0, '0);
    send_rect4(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    drain();
    c = '{default: Q_MAX};
    load_transform(c, 1'b0);
    send_rect4(Q_MAX, Q_MAX, Q_MIN, Q_MIN);
    send_rect4(32'h0000_0001, -32'sh0000_0001, 32'h0000_0002, 32'h0000_0003);
    send_rect4('0, '0, '0, '0);
    drain();
    c = '{default: Q_MIN};
    load_transform(c, 1'b0);
    send_rect4(Q_MIN, Q_MIN, Q_MAX, Q_MAX);
    send_rect4(32'h0000_0001, 32'h0000_0001, -32'sh0000_0001, -32'sh0000_0001);
    send_rect4('0, '0, '0, '0);
    drain();
  endtask

  // Random transforms, each followed by a burst of random rectangles.
  task automatic test_random_transforms;
    coef_t c;
    for (int s = 0; s < RAND_SETS; s++) begin
      c.coef_xx  = rand_weight();
      c.coef_xy  = rand_weight();
      c.offset_x = rand_coord();
      c.coef_yx  = rand_weight();
      c.coef_yy  = rand_weight();
      c.offset_y = rand_coord();
      load_transform(c, (s % 4) == 0);
      gap_max = ((s % 3) == 0) ? 0 : 6;
      for (int i = 0; i < SET_ITEMS; i++)
        send_rect4(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    gap_max = 6;
  endtask

  // Field comparison of one returned box.
  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, got_v);
    end
  endfunction

  // Each strobed box is matched against the oldest one owed.
  always @(posedge clk) begin
    box_t want;
    if (!rst && done) begin
      if (pending_boxes.size() == 0) begin
        err_count++;
        $display("%0t: unexpected box, expected none, actual %h", $realtime, box);
      end else begin
        want = pending_boxes.pop_front();
        check_field("box_left", want.box_left, box.box_left);
        check_field("box_top", want.box_top, box.box_top);
        check_field("box_width", {1'b0, want.box_width}, {1'b0, box.box_width});
        check_field("box_height", {1'b0, want.box_height}, {1'b0, box.box_height});
        check_field("range_overflow", {31'b0, want.range_overflow},
                    {31'b0, box.range_overflow});
        boxes_checked++;
        if (want.range_overflow) boxes_saturated++;
      end
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("%0t: no progress for %0d cycles", $realtime, IDLE_MAX);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    coef_model.coef_xx  = Q_ONE;
    coef_model.coef_xy  = '0;
    coef_model.offset_x = '0;
    coef_model.coef_yx  = '0;
    coef_model.coef_yy  = Q_ONE;
    coef_model.offset_y = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_extremes();
    test_register_set();
    test_random_transforms();
    $display("Covered %0d rectangles and %0d boxes, %0d of them saturated.",
             rects_sent, boxes_checked, boxes_saturated);
    $display("Made %0d register writes across %0d loaded transforms.",
             reg_writes, transforms_used);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/arbb_pkg.sv
hdl/arbb_cfg_regs.sv
hdl/arbb_axis.sv
hdl/affine_rect_bounding_box_core.sv
tb/tb_affine_rect_bounding_box_core.sv
